// ===== design/bdim_pkg.sv =====
// shared codes and types for the block distribution index map
// no dependencies
`default_nettype none

package bdim_pkg;

   typedef enum logic {
      OP_LOCATE = 1'b0,
      OP_PLACE  = 1'b1
   } op_type;

   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOTAL_ELEMENTS   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOTAL_PARTITIONS = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INDEX_BASE       = 2'd2;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;

   typedef enum logic [3:0] {
      SETUP_IDLE = 4'b0001,
      SETUP_DIV  = 4'b0010,
      SETUP_FIN  = 4'b0100,
      SETUP_MUL  = 4'b1000
   } setup_state_type;

   typedef struct packed {
      logic busy;
      logic empty;
   } setup_status_type;

endpackage

`default_nettype wire

// ===== design/bdim_setup.sv =====
// configuration registers and derivation of block size, long-block count and boundary
// depends on bdim_pkg
`default_nettype none

module bdim_setup import bdim_pkg::*; #(
   parameter int INDEX_BITS = 32,
   parameter int PART_BITS  = 16,
   parameter int CSR_BITS   = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_BITS-1:0]       csr_wdata,
   output logic [INDEX_BITS-1:0]          n_out,
   output logic [PART_BITS-1:0]           p_out,
   output logic [INDEX_BITS-1:0]          base_out,
   output logic [INDEX_BITS-1:0]          q_out,
   output logic [PART_BITS-1:0]           l_out,
   output logic [INDEX_BITS-1:0]          e_out,
   output setup_status_type               status
);

   localparam int CNT_BITS = $clog2(INDEX_BITS);

   logic [INDEX_BITS-1:0] n_ff, n_in;
   logic [PART_BITS-1:0]  p_ff, p_in;
   logic [INDEX_BITS-1:0] base_ff, base_in;
   setup_state_type       state_ff, state_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [PART_BITS-1:0]  rem_ff, rem_in;
   logic [INDEX_BITS-1:0] quo_ff, quo_in;
   logic [INDEX_BITS-1:0] q_ff, q_in;
   logic [PART_BITS-1:0]  l_ff, l_in;
   logic [INDEX_BITS-1:0] e_ff, e_in;
   logic                  empty_ff, empty_in;
   logic [PART_BITS:0]    trial;
   logic [PART_BITS+INDEX_BITS-1:0] e_full;

   assign trial  = {rem_ff, n_ff[cnt_ff]};
   assign e_full = l_ff * q_ff;

   always_comb begin
      n_in     = n_ff;
      p_in     = p_ff;
      base_in  = base_ff;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      q_in     = q_ff;
      l_in     = l_ff;
      e_in     = e_ff;
      empty_in = empty_ff;
      unique case (state_ff)
         SETUP_IDLE: begin
         end
         SETUP_DIV: begin
            if (trial >= {1'b0, p_ff}) begin
               rem_in = PART_BITS'(trial - {1'b0, p_ff});
               quo_in = {quo_ff[INDEX_BITS-2:0], 1'b1};
            end else begin
               rem_in = trial[PART_BITS-1:0];
               quo_in = {quo_ff[INDEX_BITS-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = SETUP_FIN;
            end
         end
         SETUP_FIN: begin
            q_in     = quo_ff + INDEX_BITS'(rem_ff != '0);
            l_in     = (rem_ff == '0) ? p_ff : rem_ff;
            empty_in = (n_ff == '0) || (p_ff == '0);
            state_in = SETUP_MUL;
         end
         SETUP_MUL: begin
            e_in     = e_full[INDEX_BITS-1:0];
            state_in = SETUP_IDLE;
         end
         default: begin
            state_in = SETUP_IDLE;
         end
      endcase
      if (csr_we) begin
         unique case (csr_index)
            CSR_TOTAL_ELEMENTS:   n_in    = csr_wdata[INDEX_BITS-1:0];
            CSR_TOTAL_PARTITIONS: p_in    = csr_wdata[PART_BITS-1:0];
            CSR_INDEX_BASE:       base_in = csr_wdata[INDEX_BITS-1:0];
            default: begin
            end
         endcase
         state_in = SETUP_DIV;
         cnt_in   = CNT_BITS'(INDEX_BITS - 1);
         rem_in   = '0;
         quo_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff     <= INDEX_BITS'(1);
         p_ff     <= PART_BITS'(1);
         base_ff  <= '0;
         state_ff <= SETUP_IDLE;
         cnt_ff   <= '0;
         rem_ff   <= '0;
         quo_ff   <= '0;
         q_ff     <= INDEX_BITS'(1);
         l_ff     <= PART_BITS'(1);
         e_ff     <= INDEX_BITS'(1);
         empty_ff <= 1'b0;
      end else begin
         n_ff     <= n_in;
         p_ff     <= p_in;
         base_ff  <= base_in;
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rem_ff   <= rem_in;
         quo_ff   <= quo_in;
         q_ff     <= q_in;
         l_ff     <= l_in;
         e_ff     <= e_in;
         empty_ff <= empty_in;
      end
   end

   assign n_out        = n_ff;
   assign p_out        = p_ff;
   assign base_out     = base_ff;
   assign q_out        = q_ff;
   assign l_out        = l_ff;
   assign e_out        = e_ff;
   assign status.busy  = (state_ff != SETUP_IDLE);
   assign status.empty = empty_ff;

endmodule

`default_nettype wire

// ===== design/bdim_front.sv =====
// front end: takes items, rebases and classifies them, queues work for the back end
// depends on bdim_pkg
`default_nettype none

module bdim_front import bdim_pkg::*; #(
   parameter int INDEX_BITS = 32,
   parameter int PART_BITS  = 16,
   parameter int WORK_BITS  = 3 + PART_BITS + 3 * INDEX_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic                  op_in,
   input  wire logic [INDEX_BITS-1:0] global_in,
   input  wire logic [INDEX_BITS-1:0] local_in,
   input  wire logic [PART_BITS-1:0]  part_in,
   input  wire logic [INDEX_BITS-1:0] n_in,
   input  wire logic [PART_BITS-1:0]  p_in,
   input  wire logic [INDEX_BITS-1:0] base_in,
   input  wire logic [INDEX_BITS-1:0] q_in,
   input  wire logic [PART_BITS-1:0]  l_in,
   input  wire logic [INDEX_BITS-1:0] e_in,
   input  wire setup_status_type      status,
   output logic                       work_valid,
   output logic [WORK_BITS-1:0]       work_data,
   input  wire logic                  work_pop
);

   typedef struct packed {
      logic                  op;
      logic                  oor;
      logic                  low;
      logic [PART_BITS-1:0]  part;
      logic [INDEX_BITS-1:0] index;
      logic [INDEX_BITS-1:0] num;
      logic [INDEX_BITS-1:0] den;
   } work_type;

   logic                  a_valid_ff, a_valid_in;
   logic                  a_op_ff, a_op_in;
   logic [INDEX_BITS-1:0] a_g_ff, a_g_in;
   logic [INDEX_BITS-1:0] a_local_ff, a_local_in;
   logic [PART_BITS-1:0]  a_part_ff, a_part_in;

   work_type                  queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;

   logic     accept;
   logic     queue_full;
   logic     push;
   work_type cls;
   logic     g_low;

   assign queue_full = (count_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign push       = a_valid_ff && !queue_full;
   assign req_tready = !status.busy && (!a_valid_ff || !queue_full);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      a_valid_in = a_valid_ff;
      a_op_in    = a_op_ff;
      a_g_in     = a_g_ff;
      a_local_in = a_local_ff;
      a_part_in  = a_part_ff;
      if (accept) begin
         a_valid_in = 1'b1;
         a_op_in    = op_in;
         a_g_in     = global_in - base_in;
         a_local_in = local_in;
         a_part_in  = part_in;
      end else if (push) begin
         a_valid_in = 1'b0;
      end
   end

   // locate splits into the long-block or short-block region
   assign g_low = (a_g_ff < e_in);

   always_comb begin
      cls.op    = a_op_ff;
      cls.part  = a_part_ff;
      cls.index = a_g_ff;
      cls.num   = '0;
      cls.den   = INDEX_BITS'(1);
      if (a_op_ff == OP_LOCATE) begin
         cls.low = g_low;
         cls.oor = status.empty || (a_g_ff >= n_in) || (!g_low && (q_in == INDEX_BITS'(1)));
         cls.num = g_low ? a_g_ff : a_g_ff - e_in;
         cls.den = g_low ? q_in : q_in - 1'b1;
      end else begin
         cls.low   = (a_part_ff < l_in);
         cls.oor   = status.empty || (a_part_ff >= p_in);
         cls.index = a_local_ff;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (work_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      case ({push, work_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      a_op_ff    <= a_op_in;
      a_g_ff     <= a_g_in;
      a_local_ff <= a_local_in;
      a_part_ff  <= a_part_in;
      if (push) begin
         queue_ff[wr_ptr_ff] <= cls;
      end
   end

   assign work_valid = (count_ff != '0);
   assign work_data  = queue_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ===== design/bdim_back.sv =====
// back end: pipelined restoring divider, partition start and size, result register
// depends on bdim_pkg
`default_nettype none

module bdim_back import bdim_pkg::*; #(
   parameter int INDEX_BITS = 32,
   parameter int PART_BITS  = 16,
   parameter int WORK_BITS  = 3 + PART_BITS + 3 * INDEX_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  work_valid,
   input  wire logic [WORK_BITS-1:0]  work_data,
   output logic                       work_pop,
   input  wire logic [INDEX_BITS-1:0] base_in,
   input  wire logic [INDEX_BITS-1:0] q_in,
   input  wire logic [PART_BITS-1:0]  l_in,
   input  wire logic [INDEX_BITS-1:0] e_in,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [PART_BITS-1:0]       part_out,
   output logic [INDEX_BITS-1:0]      local_out,
   output logic [INDEX_BITS-1:0]      global_out,
   output logic [INDEX_BITS-1:0]      first_out,
   output logic [INDEX_BITS-1:0]      size_out,
   output logic                       oor_out
);

   localparam int DIV_STAGES = INDEX_BITS;

   typedef struct packed {
      logic                  op;
      logic                  oor;
      logic                  low;
      logic [PART_BITS-1:0]  part;
      logic [INDEX_BITS-1:0] index;
      logic [INDEX_BITS-1:0] num;
      logic [INDEX_BITS-1:0] den;
   } work_type;

   typedef struct packed {
      logic                  valid;
      logic                  op;
      logic                  oor;
      logic                  low;
      logic [PART_BITS-1:0]  part;
      logic [INDEX_BITS-1:0] index;
      logic [INDEX_BITS-1:0] num;
      logic [INDEX_BITS-1:0] den;
      logic [INDEX_BITS-1:0] rem;
      logic [INDEX_BITS-1:0] quo;
   } div_type;

   typedef struct packed {
      logic                  valid;
      logic                  op;
      logic                  oor;
      logic                  low;
      logic [PART_BITS-1:0]  part;
      logic [INDEX_BITS-1:0] local_idx;
      logic [INDEX_BITS-1:0] first_rel;
      logic [PART_BITS-1:0]  mul_a;
      logic [INDEX_BITS-1:0] mul_b;
      logic [INDEX_BITS-1:0] size;
   } fin_type;

   logic     en;
   work_type head;
   div_type  div_ff [DIV_STAGES];
   div_type  div_in [DIV_STAGES];
   fin_type  f1_ff, f1_in;
   fin_type  f2_ff, f2_in;
   fin_type  f3_ff, f3_in;
   div_type  last;
   logic [PART_BITS+INDEX_BITS-1:0] prod_full;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PART_BITS-1:0]  rsp_part_ff, rsp_part_in;
   logic [INDEX_BITS-1:0] rsp_local_ff, rsp_local_in;
   logic [INDEX_BITS-1:0] rsp_global_ff, rsp_global_in;
   logic [INDEX_BITS-1:0] rsp_first_ff, rsp_first_in;
   logic [INDEX_BITS-1:0] rsp_size_ff, rsp_size_in;
   logic                  rsp_oor_ff, rsp_oor_in;

   assign en       = !rsp_valid_ff || rsp_tready;
   assign work_pop = en && work_valid;
   assign head     = work_type'(work_data);

   // one quotient bit per stage, most significant first
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      div_type               src;
      logic [INDEX_BITS:0]   trial;

      if (k == 0) begin : g_first
         always_comb begin
            src       = '0;
            src.valid = work_pop;
            src.op    = head.op;
            src.oor   = head.oor;
            src.low   = head.low;
            src.part  = head.part;
            src.index = head.index;
            src.num   = head.num;
            src.den   = head.den;
         end
      end else begin : g_next
         assign src = div_ff[k-1];
      end

      assign trial = {src.rem, src.num[INDEX_BITS-1-k]};

      always_comb begin
         div_in[k] = src;
         if (trial >= {1'b0, src.den}) begin
            div_in[k].rem                  = INDEX_BITS'(trial - {1'b0, src.den});
            div_in[k].quo[INDEX_BITS-1-k]  = 1'b1;
         end else begin
            div_in[k].rem = trial[INDEX_BITS-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_ff[k] <= '0;
         end else if (en) begin
            div_ff[k] <= div_in[k];
         end
      end
   end

   assign last = div_ff[DIV_STAGES-1];

   always_comb begin
      f1_in.valid     = last.valid;
      f1_in.op        = last.op;
      f1_in.oor       = last.oor;
      f1_in.low       = last.low;
      f1_in.size      = last.low ? q_in : q_in - 1'b1;
      f1_in.mul_a     = last.low ? last.part : last.part - l_in;
      f1_in.mul_b     = last.low ? q_in : q_in - 1'b1;
      if (last.op == OP_LOCATE) begin
         f1_in.part      = last.low ? PART_BITS'(last.quo) : PART_BITS'(last.quo) + l_in;
         f1_in.local_idx = last.rem;
         f1_in.first_rel = last.index - last.rem;
      end else begin
         f1_in.part      = last.part;
         f1_in.local_idx = last.index;
         f1_in.first_rel = '0;
      end
   end

   assign prod_full = f1_ff.mul_a * f1_ff.mul_b;

   always_comb begin
      f2_in = f1_ff;
      if (f1_ff.op == OP_PLACE) begin
         f2_in.first_rel = prod_full[INDEX_BITS-1:0];
      end
   end

   always_comb begin
      f3_in = f2_ff;
      if (f2_ff.op == OP_PLACE && !f2_ff.low) begin
         f3_in.first_rel = e_in + f2_ff.first_rel;
      end
      f3_in.oor = f2_ff.oor || (f2_ff.local_idx >= f2_ff.size);
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_part_in   = rsp_part_ff;
      rsp_local_in  = rsp_local_ff;
      rsp_global_in = rsp_global_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_oor_in    = rsp_oor_ff;
      if (en) begin
         rsp_valid_in = f3_ff.valid;
         rsp_oor_in   = f3_ff.oor;
         if (f3_ff.oor) begin
            rsp_part_in   = '0;
            rsp_local_in  = '0;
            rsp_global_in = '0;
            rsp_first_in  = '0;
            rsp_size_in   = '0;
         end else begin
            rsp_part_in   = f3_ff.part;
            rsp_local_in  = f3_ff.local_idx;
            rsp_global_in = f3_ff.first_rel + base_in + f3_ff.local_idx;
            rsp_first_in  = f3_ff.first_rel + base_in;
            rsp_size_in   = f3_ff.size;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_ff        <= '0;
         f2_ff        <= '0;
         f3_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en) begin
            f1_ff <= f1_in;
            f2_ff <= f2_in;
            f3_ff <= f3_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_part_ff   <= rsp_part_in;
      rsp_local_ff  <= rsp_local_in;
      rsp_global_ff <= rsp_global_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_oor_ff    <= rsp_oor_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign part_out   = rsp_part_ff;
   assign local_out  = rsp_local_ff;
   assign global_out = rsp_global_ff;
   assign first_out  = rsp_first_ff;
   assign size_out   = rsp_size_ff;
   assign oor_out    = rsp_oor_ff;

endmodule

`default_nettype wire

// ===== design/block_distribution_index_map.sv =====
// top level of the block distribution index map: setup, front end, back end
// depends on bdim_pkg, bdim_setup, bdim_front, bdim_back
//
// channel   dir   handshake              payload
// req       in    req_tvalid/req_tready  tdata global, local, part; tuser operation
// rsp       out   rsp_tvalid/rsp_tready  tdata part, local, global, first, size; tuser flag
// csr       in    csr_we                 csr_index, csr_wdata
//
// one item per cycle sustained while rsp_tready is high and no derivation runs; an item
// passes the input register, the queue, the one-bit-per-stage divider, f1 to f3 and the
// rsp register in the back end; a register write starts a serial derivation of the block
// size (divide, finish, multiply), during which req_tready is low
// synchronous reset gives one element in one partition with base zero
// the queue lets the front keep taking items while the result side stalls, until the queue is full
`default_nettype none

module block_distribution_index_map import bdim_pkg::*; #(
   parameter int INDEX_BITS     = 32,
   parameter int PART_BITS      = 16,
   localparam int REQ_DATA_BITS = ((2 * INDEX_BITS + PART_BITS + 7) / 8) * 8,
   localparam int RSP_DATA_BITS = ((4 * INDEX_BITS + PART_BITS + 7) / 8) * 8,
   localparam int CSR_BITS      = (INDEX_BITS > PART_BITS) ? INDEX_BITS : PART_BITS
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // global_in, local_in, part_in
   input  wire logic [REQ_DATA_BITS-1:0]  req_tdata,
   // operation
   input  wire logic                      req_tuser,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // part_out, local_out, global_out, first_out, size_out
   output logic [RSP_DATA_BITS-1:0]       rsp_tdata,
   // out_of_range
   output logic                           rsp_tuser,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_BITS-1:0]       csr_wdata
);

   localparam int WORK_BITS     = 3 + PART_BITS + 3 * INDEX_BITS;

   logic [INDEX_BITS-1:0] n_val, base_val, q_val, e_val;
   logic [PART_BITS-1:0]  p_val, l_val;
   setup_status_type      status;
   logic                  work_valid;
   logic [WORK_BITS-1:0]  work_data;
   logic                  work_pop;
   logic [PART_BITS-1:0]  part_out;
   logic [INDEX_BITS-1:0] local_out, global_out, first_out, size_out;
   logic                  oor_out;

   bdim_setup #(
      .INDEX_BITS (INDEX_BITS),
      .PART_BITS  (PART_BITS),
      .CSR_BITS   (CSR_BITS)
   ) u_setup (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .n_out     (n_val),
      .p_out     (p_val),
      .base_out  (base_val),
      .q_out     (q_val),
      .l_out     (l_val),
      .e_out     (e_val),
      .status    (status)
   );

   bdim_front #(
      .INDEX_BITS (INDEX_BITS),
      .PART_BITS  (PART_BITS),
      .WORK_BITS  (WORK_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .op_in      (req_tuser),
      .global_in  (req_tdata[INDEX_BITS-1:0]),
      .local_in   (req_tdata[2*INDEX_BITS-1:INDEX_BITS]),
      .part_in    (req_tdata[2*INDEX_BITS+PART_BITS-1:2*INDEX_BITS]),
      .n_in       (n_val),
      .p_in       (p_val),
      .base_in    (base_val),
      .q_in       (q_val),
      .l_in       (l_val),
      .e_in       (e_val),
      .status     (status),
      .work_valid (work_valid),
      .work_data  (work_data),
      .work_pop   (work_pop)
   );

   bdim_back #(
      .INDEX_BITS (INDEX_BITS),
      .PART_BITS  (PART_BITS),
      .WORK_BITS  (WORK_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .work_valid (work_valid),
      .work_data  (work_data),
      .work_pop   (work_pop),
      .base_in    (base_val),
      .q_in       (q_val),
      .l_in       (l_val),
      .e_in       (e_val),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .part_out   (part_out),
      .local_out  (local_out),
      .global_out (global_out),
      .first_out  (first_out),
      .size_out   (size_out),
      .oor_out    (oor_out)
   );

   assign rsp_tdata = RSP_DATA_BITS'({size_out, first_out, global_out, local_out, part_out});
   assign rsp_tuser = oor_out;

endmodule

`default_nettype wire

// ===== sim/tb_block_distribution_index_map.sv =====
`timescale 1ns / 1ps
// self-checking testbench for block_distribution_index_map: locate and place items with
// per-field comparison against a scoreboard that predicts the block distribution mapping
// depends on bdim_pkg and the block_distribution_index_map design

module tb_block_distribution_index_map;
   import bdim_pkg::*;

   localparam int IDX_W       = 32;
   localparam int PART_W      = 16;
   localparam int REQ_W       = 80;
   localparam int RSP_W       = 144;
   localparam int STALL_LIMIT = 4000;

   typedef struct packed {
      logic [PART_W-1:0] part;
      logic [IDX_W-1:0]  loc_idx;
      logic [IDX_W-1:0]  global_idx;
      logic [IDX_W-1:0]  first;
      logic [IDX_W-1:0]  blk_size;
      logic              flag;
   } map_result_type;

   class index_map_scoreboard;
      logic [IDX_W-1:0]  elements;
      logic [PART_W-1:0] partitions;
      logic [IDX_W-1:0]  base;
      longint unsigned   big_size;
      longint unsigned   big_count;
      longint unsigned   split_point;
      map_result_type    expected_q[$];
      int                error_count;

      function new();
         elements    = 1;
         partitions  = 1;
         base        = 0;
         error_count = 0;
         derive();
      endfunction

      function void derive();
         longint unsigned n;
         longint unsigned p;
         n = elements;
         p = partitions;
         if (n != 0 && p != 0) begin
            big_size  = n / p + ((n % p) != 0 ? 1 : 0);
            big_count = n % p;
            if (big_count == 0) big_count = p;
            split_point = big_count * big_size;
         end else begin
            big_size    = 0;
            big_count   = 0;
            split_point = 0;
         end
      endfunction

      function void set_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [IDX_W-1:0] val);
         case (idx)
            CSR_TOTAL_ELEMENTS:   elements   = val;
            CSR_TOTAL_PARTITIONS: partitions = val[PART_W-1:0];
            CSR_INDEX_BASE:       base       = val;
            default: ;
         endcase
         derive();
      endfunction

      function longint unsigned part_size(longint unsigned pt);
         return (pt < big_count) ? big_size : big_size - 1;
      endfunction

      function longint unsigned part_first(longint unsigned pt);
         if (pt < big_count) return pt * big_size;
         return split_point + (pt - big_count) * (big_size - 1);
      endfunction

      function map_result_type map_index(op_type op, logic [IDX_W-1:0] g,
                                         logic [IDX_W-1:0] l, logic [PART_W-1:0] pt);
         map_result_type   res;
         map_result_type   miss;
         logic [IDX_W-1:0] off32;
         logic [IDX_W-1:0] first32;
         longint unsigned off;
         longint unsigned short_size;
         longint unsigned part;
         longint unsigned loc;
         longint unsigned sz;
         miss      = '0;
         miss.flag = 1'b1;
         res       = '0;
         if (elements == 0 || partitions == 0) return miss;
         if (op == OP_LOCATE) begin
            off32 = g - base;
            off   = off32;
            if (off >= elements) return miss;
            if (off < split_point) begin
               part = off / big_size;
               loc  = off % big_size;
            end else begin
               short_size = big_size - 1;
               if (short_size == 0) return miss;
               part = big_count + (off - split_point) / short_size;
               loc  = (off - split_point) % short_size;
            end
         end else begin
            part = pt;
            loc  = l;
            if (part >= partitions) return miss;
         end
         sz = part_size(part);
         if (loc >= sz) return miss;
         first32        = IDX_W'(part_first(part) + base);
         res.part       = PART_W'(part);
         res.loc_idx    = IDX_W'(loc);
         res.first      = first32;
         res.global_idx = first32 + IDX_W'(loc);
         res.blk_size   = IDX_W'(sz);
         res.flag       = 1'b0;
         return res;
      endfunction

      function void note_request(op_type op, logic [IDX_W-1:0] g, logic [IDX_W-1:0] l,
                                 logic [PART_W-1:0] pt);
         expected_q.push_back(map_index(op, g, l, pt));
      endfunction

      function void compare(string name, logic [IDX_W-1:0] want, logic [IDX_W-1:0] got);
         if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         end
      endfunction

      function void check_response(logic [RSP_W-1:0] data, logic flag);
         map_result_type want;
         if (expected_q.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, expected none, actual %h flag %b",
                     $time, data, flag);
            return;
         end
         want = expected_q.pop_front();
         compare("part_out",     want.part,       data[15:0]);
         compare("local_out",    want.loc_idx,    data[47:16]);
         compare("global_out",   want.global_idx, data[79:48]);
         compare("first_out",    want.first,      data[111:80]);
         compare("size_out",     want.blk_size,   data[143:112]);
         compare("out_of_range", want.flag,       flag);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_W-1:0]          req_tdata  = '0;
   logic                      req_tuser  = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_W-1:0]          rsp_tdata;
   logic                      rsp_tuser;
   logic                      csr_we     = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [IDX_W-1:0]          csr_wdata  = '0;

   int  idle_mode   = 0;
   int  items_sent  = 0;
   int  stall_cycles = 0;

   index_map_scoreboard sb = new();

   block_distribution_index_map uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      case (idle_mode)
         0:       rsp_tready <= ($urandom_range(0, 99) >= 79);
         1:       rsp_tready <= ($urandom_range(0, 99) >= 32);
         default: rsp_tready <= 1'b1;
      endcase
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_request(op_type'(req_tuser), req_tdata[31:0], req_tdata[63:32],
                            req_tdata[79:64]);
         if (rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tdata, rsp_tuser);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic bit sender_idles();
      case (idle_mode)
         0:       return $urandom_range(0, 99) < 32;
         1:       return $urandom_range(0, 99) < 79;
         default: return 1'b0;
      endcase
   endfunction

   task automatic send_item(op_type op, logic [IDX_W-1:0] g, logic [IDX_W-1:0] l,
                            logic [PART_W-1:0] pt);
      idle_mode = (items_sent < 510) ? 0 : (items_sent < 1020) ? 1 : 2;
      while (sender_idles()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {pt, l, g};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain();
      while (sb.pending() != 0) @(posedge clock);
      repeat (IDX_W + 8) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_BITS-1:0] idx, logic [IDX_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_reg(idx, val);
      // let the size derivation start, then wait for it to finish
      repeat (2) @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic apply_setting(logic [IDX_W-1:0] n, logic [PART_W-1:0] p,
                                logic [IDX_W-1:0] base);
      logic [15:0] junk;
      junk = 16'($urandom);
      req_tvalid <= 1'b0;
      drain();
      csr_write(CSR_TOTAL_ELEMENTS, n);
      csr_write(CSR_TOTAL_PARTITIONS, {junk, p});
      csr_write(CSR_INDEX_BASE, base);
   endtask

   task automatic random_items(int count);
      int               r;
      int               sel;
      longint unsigned  n;
      longint unsigned  p;
      longint unsigned  off;
      longint unsigned  pt;
      longint unsigned  sz;
      logic [IDX_W-1:0] g;
      logic [IDX_W-1:0] l;
      logic [IDX_W-1:0] off32;
      logic [PART_W-1:0] part;
      op_type           op;
      n = sb.elements;
      p = sb.partitions;
      for (int i = 0; i < count; i++) begin
         r    = $urandom_range(0, 99);
         g    = $urandom;
         l    = $urandom;
         part = PART_W'($urandom);
         op   = op_type'($urandom_range(0, 1));
         if (r >= 12 && n != 0 && p != 0) begin
            sel = $urandom_range(0, 5);
            if (r < 56) begin
               op = OP_LOCATE;
               case (sel)
                  1:       off = sb.split_point + $urandom_range(0, 3) - 2;
                  2:       off = n + $urandom_range(0, 3) - 2;
                  3:       off = $urandom_range(0, 3);
                  4:       off = $urandom;
                  default: off = $urandom_range(0, IDX_W'(n - 1));
               endcase
               off32 = IDX_W'(off);
               g     = sb.base + off32;
            end else begin
               op = OP_PLACE;
               case (sel)
                  3:       pt = sb.big_count + $urandom_range(0, 1) - 1;
                  4:       pt = p + $urandom_range(0, 1) - 1;
                  default: pt = $urandom_range(0, IDX_W'(p - 1));
               endcase
               part = PART_W'(pt);
               sz   = (part < p) ? sb.part_size(part) : 1;
               if ($urandom_range(0, 3) == 0 || sz == 0)
                  l = IDX_W'(sz + $urandom_range(0, 1) - 1);
               else l = $urandom_range(0, IDX_W'(sz - 1));
            end
         end
         send_item(op, g, l, part);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset distribution: one element in one partition
      send_item(OP_LOCATE, 32'd0, 32'd0, 16'd0);
      send_item(OP_LOCATE, 32'd1, 32'd0, 16'd0);
      send_item(OP_PLACE, 32'd0, 32'd0, 16'd0);
      send_item(OP_PLACE, 32'd0, 32'd1, 16'd0);
      send_item(OP_PLACE, 32'd0, 32'd0, 16'd1);

      // 100 over 7: two partitions of 15, five of 14, split at 30
      apply_setting(32'd100, 16'd7, 32'd0);
      send_item(OP_LOCATE, 32'd0,  32'hFFFF_FFFF, 16'hFFFF);
      send_item(OP_LOCATE, 32'd14, 32'd0, 16'd0);
      send_item(OP_LOCATE, 32'd15, 32'd0, 16'd0);
      send_item(OP_LOCATE, 32'd29, 32'd0, 16'd0);
      send_item(OP_LOCATE, 32'd30, 32'd0, 16'd0);
      send_item(OP_LOCATE, 32'd99, 32'd0, 16'd0);
      send_item(OP_LOCATE, 32'd100, 32'd0, 16'd0);
      send_item(OP_LOCATE, 32'hFFFF_FFFF, 32'd0, 16'd0);
      send_item(OP_PLACE, 32'd0, 32'd0,  16'd0);
      send_item(OP_PLACE, 32'd0, 32'd14, 16'd1);
      send_item(OP_PLACE, 32'd0, 32'd15, 16'd1);
      send_item(OP_PLACE, 32'd0, 32'd13, 16'd2);
      send_item(OP_PLACE, 32'd0, 32'd14, 16'd2);
      send_item(OP_PLACE, 32'd0, 32'd13, 16'd6);
      send_item(OP_PLACE, 32'd0, 32'd0,  16'd7);
      send_item(OP_PLACE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
      send_item(OP_PLACE, 32'd0, 32'hFFFF_FFFF, 16'd0);
      random_items(140);

      apply_setting(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
      random_items(150);
      // more partitions than elements: empty partitions
      apply_setting(32'd1, 16'hFFFF, 32'h8000_0000);
      random_items(120);
      apply_setting(32'd196605, 16'hFFFF, $urandom);
      random_items(150);
      // empty distributions
      apply_setting(32'd0, 16'd5, $urandom);
      random_items(60);
      apply_setting(32'd10, 16'd0, 32'd0);
      random_items(60);
      apply_setting($urandom_range(1, 5000), PART_W'($urandom_range(1, 64)), $urandom);
      random_items(200);
      apply_setting($urandom | 32'd1, PART_W'($urandom_range(1, 65535)), $urandom);
      random_items(200);
      // wrapping base with one element per partition
      apply_setting(32'd1000, 16'd1000, 32'hFFFF_FF00);
      random_items(150);
      apply_setting(32'hFFFF_FFFF, 16'd1, 32'd0);
      random_items(120);
      apply_setting(32'd37, 16'd8, 32'hFFFF_FFF0);
      random_items(200);

      req_tvalid <= 1'b0;
      drain();
      if (sb.error_count == 0 && sb.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/bdim_pkg.sv
design/bdim_setup.sv
design/bdim_front.sv
design/bdim_back.sv
design/block_distribution_index_map.sv
sim/tb_block_distribution_index_map.sv
